FILE: design/pmcb_pkg.sv
// ----------------------------------------------------------------------------
// pmcb_pkg: shared types and constants of the counter bank
// Opcodes, control word bits, register indexes and the structs that pass
// between the sequencer, the counter store and the top level.
// ----------------------------------------------------------------------------
package pmcb_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SWINC  = 3'd2,
    OP_OVFSET = 3'd3,
    OP_CTRL   = 3'd4,
    OP_EVTYPE = 3'd5,
    OP_SYNC   = 3'd6
  } pmcb_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_INC,
    S_FIN
  } pmcb_state_e;

  // configuration register indexes
  localparam logic [1:0] CFG_IMPL = 2'd0;
  localparam logic [1:0] CFG_CEN  = 2'd1;
  localparam logic [1:0] CFG_IEN  = 2'd2;

  localparam logic [4:0] CYCLE_IDX = 5'd31;

  // control word bits
  localparam int unsigned CTRL_E  = 0;
  localparam int unsigned CTRL_P  = 1;
  localparam int unsigned CTRL_C  = 2;
  localparam int unsigned CTRL_LC = 6;

  localparam int unsigned TYPE_MAX_W = 16;

  typedef struct packed {
    logic [4:0]  impl_n;
    logic [31:0] cen;
    logic [31:0] ien;
  } pmcb_cfg_t;

  typedef struct packed {
    logic                  rd_en;
    logic [4:0]            rd_addr;
    logic                  cnt_we;
    logic                  ty_we;
    logic [4:0]            wr_addr;
    logic [31:0]           cnt_wdata;
    logic [TYPE_MAX_W-1:0] ty_wdata;
    logic                  clr;
  } pmcb_store_req_t;

  typedef struct packed {
    logic [31:0]           cnt;
    logic [TYPE_MAX_W-1:0] ty;
  } pmcb_store_rsp_t;

  typedef struct packed {
    logic        chg;
    logic        irq;
    logic [31:0] ovf;
    logic [63:0] rv;
  } pmcb_res_t;

endpackage

FILE: design/pmcb_store.sv
// ----------------------------------------------------------------------------
// pmcb_store: event counter and event type memories
// One write port and one registered read port per memory. Valid bits make
// unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module pmcb_store
  import pmcb_pkg::*;
#(
  parameter int unsigned EVENT_COUNTERS   = 31,
  parameter int unsigned EVENT_TYPE_WIDTH = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pmcb_store_req_t req_i,
  output pmcb_store_rsp_t rsp_o
);

  localparam int unsigned AW = (EVENT_COUNTERS > 1) ? $clog2(EVENT_COUNTERS) : 1;

  logic [31:0]                 cnt_mem [EVENT_COUNTERS];
  logic [EVENT_TYPE_WIDTH-1:0] ty_mem  [EVENT_COUNTERS];
  logic [EVENT_COUNTERS-1:0]   cnt_vld_q;
  logic [EVENT_COUNTERS-1:0]   ty_vld_q;
  logic [31:0]                 cnt_rd_q;
  logic [EVENT_TYPE_WIDTH-1:0] ty_rd_q;
  logic                        cnt_rd_vld_q;
  logic                        ty_rd_vld_q;

  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  assign wa = req_i.wr_addr[AW-1:0];
  assign ra = req_i.rd_addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[wa] <= req_i.cnt_wdata;
    end
    if (req_i.ty_we) begin
      ty_mem[wa] <= req_i.ty_wdata[EVENT_TYPE_WIDTH-1:0];
    end
    if (req_i.rd_en) begin
      cnt_rd_q <= cnt_mem[ra];
      ty_rd_q  <= ty_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      ty_vld_q     <= '0;
      cnt_rd_vld_q <= 1'b0;
      ty_rd_vld_q  <= 1'b0;
    end else begin
      // a clear drops every event counter at once
      if (req_i.clr) begin
        cnt_vld_q <= '0;
      end else if (req_i.cnt_we) begin
        cnt_vld_q[wa] <= 1'b1;
      end
      if (req_i.ty_we) begin
        ty_vld_q[wa] <= 1'b1;
      end
      if (req_i.rd_en) begin
        cnt_rd_vld_q <= cnt_vld_q[ra];
        ty_rd_vld_q  <= ty_vld_q[ra];
      end
    end
  end

  assign rsp_o.cnt = cnt_rd_vld_q ? cnt_rd_q : 32'd0;
  assign rsp_o.ty  = ty_rd_vld_q ?
                     TYPE_MAX_W'(ty_rd_q) : {TYPE_MAX_W{1'b0}};

endmodule

FILE: design/pmcb_seq.sv
// ----------------------------------------------------------------------------
// pmcb_seq: access sequencer with the shared increment unit
// Executes one access at a time, walks the event counters for a software
// increment and forms the result word with the interrupt level.
// ----------------------------------------------------------------------------
module pmcb_seq
  import pmcb_pkg::*;
#(
  parameter int unsigned EVENT_COUNTERS = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pmcb_cfg_t       cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      in_op_i,
  input  logic [4:0]      in_idx_i,
  input  logic [63:0]     in_data_i,
  output pmcb_store_req_t req_o,
  input  pmcb_store_rsp_t rsp_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pmcb_res_t       res_o
);

  localparam logic [4:0] LAST_IDX = 5'(EVENT_COUNTERS - 1);
  localparam logic [4:0] NUM_EVT  = 5'(EVENT_COUNTERS);

  pmcb_state_e state_q, state_d;
  pmcb_op_e    op_q, op_d;
  logic [4:0]  idx_q, idx_d;
  logic [63:0] data_q, data_d;
  logic [4:0]  walk_q, walk_d;
  logic [63:0] rv_q, rv_d;
  logic [63:0] cyc_q, cyc_d;
  logic [31:0] ovf_q, ovf_d;
  logic        en_q, en_d;
  logic        lc_q, lc_d;
  logic        irq_q, irq_d;

  logic [31:0] inc_mask;
  logic [31:0] cnt_inc;
  logic        inc_hit;
  logic [31:0] valid_mask;
  logic        irq_new;
  logic        evt_present;

  assign inc_mask    = data_q[31:0];
  assign cnt_inc     = rsp_i.cnt + 32'd1;
  assign inc_hit     = inc_mask[walk_q] && (rsp_i.ty == '0) && cfg_i.cen[walk_q];
  assign valid_mask  = ~(32'hffff_ffff << cfg_i.impl_n) | 32'h8000_0000;
  assign irq_new     = en_q && ((ovf_q & cfg_i.cen & cfg_i.ien & valid_mask) != 32'd0);
  assign evt_present = idx_q < NUM_EVT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cyc_q   <= '0;
      ovf_q   <= '0;
      en_q    <= 1'b0;
      lc_q    <= 1'b0;
      irq_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cyc_q   <= cyc_d;
      ovf_q   <= ovf_d;
      en_q    <= en_d;
      lc_q    <= lc_d;
      irq_q   <= irq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    data_q <= data_d;
    walk_q <= walk_d;
    rv_q   <= rv_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    data_d      = data_q;
    walk_d      = walk_q;
    rv_d        = rv_q;
    cyc_d       = cyc_q;
    ovf_d       = ovf_q;
    en_d        = en_q;
    lc_d        = lc_q;
    irq_d       = irq_q;
    req_o       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o.rv    = rv_q;
    res_o.ovf   = ovf_q;
    res_o.irq   = irq_new;
    res_o.chg   = irq_new ^ irq_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d          = pmcb_op_e'(in_op_i);
          idx_d         = in_idx_i;
          data_d        = in_data_i;
          walk_d        = 5'd0;
          rv_d          = 64'd0;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = (in_op_i == OP_SWINC) ? 5'd0 : in_idx_i;
          if (in_op_i == OP_READ) begin
            state_d = S_READ;
          end else if (in_op_i == OP_SWINC) begin
            state_d = S_INC;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_READ: begin
        if (idx_q == CYCLE_IDX) begin
          rv_d = lc_q ? cyc_q : {32'd0, cyc_q[31:0]};
        end else if (evt_present) begin
          rv_d = {32'd0, rsp_i.cnt};
        end
        state_d = S_FIN;
      end
      S_EXEC: begin
        case (op_q)
          OP_WRITE: begin
            if (idx_q == CYCLE_IDX) begin
              cyc_d = data_q;
            end else if (evt_present) begin
              req_o.cnt_we    = 1'b1;
              req_o.wr_addr   = idx_q;
              req_o.cnt_wdata = data_q[31:0];
            end
          end
          OP_OVFSET: begin
            ovf_d = ovf_q | data_q[31:0];
          end
          OP_CTRL: begin
            en_d      = data_q[CTRL_E];
            lc_d      = data_q[CTRL_LC];
            req_o.clr = data_q[CTRL_P];
            if (data_q[CTRL_C]) begin
              cyc_d = 64'd0;
            end
          end
          OP_EVTYPE: begin
            if (evt_present) begin
              req_o.ty_we    = 1'b1;
              req_o.wr_addr  = idx_q;
              req_o.ty_wdata = data_q[TYPE_MAX_W-1:0];
            end
          end
          default: begin
          end
        endcase
        state_d = S_FIN;
      end
      S_INC: begin
        // update the counter read last cycle, fetch the next one
        if (inc_hit) begin
          req_o.cnt_we    = 1'b1;
          req_o.wr_addr   = walk_q;
          req_o.cnt_wdata = cnt_inc;
          if (cnt_inc == 32'd0) begin
            ovf_d[walk_q] = 1'b1;
          end
        end
        if (walk_q == LAST_IDX) begin
          state_d = S_FIN;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = walk_q + 5'd1;
          walk_d        = walk_q + 5'd1;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          irq_d   = irq_new;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/perf_monitor_counter_bank_top.sv
// ----------------------------------------------------------------------------
// perf_monitor_counter_bank_top: performance monitor counter bank
// An access runs from the input word through the sequencer states to a
// registered output word; a software increment walks the event counters.
// Flow: one access at a time; the next word is taken once the last result
// leaves the sequencer, and the walk reads one counter per cycle.
// Reset clears all counters, types, flags and control state at once.
// ----------------------------------------------------------------------------
module perf_monitor_counter_bank_top
  import pmcb_pkg::*;
#(
  parameter int unsigned EVENT_COUNTERS   = 31,
  parameter int unsigned EVENT_TYPE_WIDTH = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] opcode, [7:3] counter_index, [71:8] write_data
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] read_value, [95:64] overflow_flags, [96] ovf_irq,
  // [97] irq_changed, [103:98] zero
  output logic [103:0] m_axis_tdata
);

  pmcb_cfg_t       cfg_q;
  pmcb_store_req_t req;
  pmcb_store_rsp_t rsp;
  pmcb_res_t       res;
  logic            res_valid;
  logic            res_ready;
  logic            out_valid_q;
  pmcb_res_t       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.impl_n <= 5'd31;
      cfg_q.cen    <= '0;
      cfg_q.ien    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMPL: cfg_q.impl_n <= cfg_wdata_i[4:0];
        CFG_CEN:  cfg_q.cen    <= cfg_wdata_i;
        CFG_IEN:  cfg_q.ien    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  pmcb_seq #(
    .EVENT_COUNTERS(EVENT_COUNTERS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tdata[2:0]),
    .in_idx_i   (s_axis_tdata[7:3]),
    .in_data_i  (s_axis_tdata[71:8]),
    .req_o      (req),
    .rsp_i      (rsp),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  pmcb_store #(
    .EVENT_COUNTERS  (EVENT_COUNTERS),
    .EVENT_TYPE_WIDTH(EVENT_TYPE_WIDTH)
  ) u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // hold the result word until the sink takes it
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

FILE: design/pmcb_checker.sv
// ----------------------------------------------------------------------------
// pmcb_checker: port-level checks of the counter bank
// Watches the stream ports and the result words over time.
// ----------------------------------------------------------------------------
module pmcb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  logic        out_hs;
  logic        prev_irq_q;
  logic [31:0] prev_ovf_q;

  assign out_hs = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_irq_q <= 1'b0;
      prev_ovf_q <= '0;
    end else if (out_hs) begin
      prev_irq_q <= m_axis_tdata[96];
      prev_ovf_q <= m_axis_tdata[95:64];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an access is in progress");

  a_irq_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs |-> m_axis_tdata[97] == (m_axis_tdata[96] != prev_irq_q))
    else $error("interrupt change flag disagrees with level history");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs |-> (m_axis_tdata[95:64] & prev_ovf_q) == prev_ovf_q)
    else $error("overflow flag lost");

  a_irq_needs_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && m_axis_tdata[96] |-> m_axis_tdata[95:64] != 32'd0)
    else $error("interrupt raised without an overflow flag");

endmodule

bind perf_monitor_counter_bank_top pmcb_checker u_pmcb_checker (.*);
